FILE: design/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and codes for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int WORD_W = 32;
  localparam int OPC_W  = 3;
  localparam int STS_W  = 3;
  localparam int STEP_W = $clog2(WORD_W);

  localparam logic [OPC_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OPC_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OPC_W-1:0] OP_SUB    = 3'd2;
  localparam logic [OPC_W-1:0] OP_MUL    = 3'd3;
  localparam logic [OPC_W-1:0] OP_DIV    = 3'd4;
  localparam logic [OPC_W-1:0] OP_REM    = 3'd5;
  localparam logic [OPC_W-1:0] OP_FINISH = 3'd6;

  localparam logic [STS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STS_W-1:0] ST_DIVZERO   = 3'd3;
  localparam logic [STS_W-1:0] ST_LEFTOVER  = 3'd4;

  typedef struct packed {
    logic             start;
    logic [OPC_W-1:0] op;
  } alu_req_t;

endpackage

FILE: design/pee_stack.sv
// ----------------------------------------------------------------------------
// pee_stack
// Operand stack storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pee_stack #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [pee_pkg::WORD_W-1:0]  wdata,
  input  logic [AW-1:0]               raddr_a,
  input  logic [AW-1:0]               raddr_b,
  output logic [pee_pkg::WORD_W-1:0]  rdata_a,
  output logic [pee_pkg::WORD_W-1:0]  rdata_b
);
  import pee_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: design/pee_alu.sv
// ----------------------------------------------------------------------------
// pee_alu
// Shared arithmetic unit: registered add, subtract and multiply, signed
// divide and remainder by a radix-2 restoring loop of one bit per cycle.
// ----------------------------------------------------------------------------
module pee_alu (
  input  logic                       clk,
  input  logic                       rst,
  input  pee_pkg::alu_req_t          req,
  input  logic [pee_pkg::WORD_W-1:0] left,
  input  logic [pee_pkg::WORD_W-1:0] right,
  output logic                       done,
  output logic [pee_pkg::WORD_W-1:0] result
);
  import pee_pkg::*;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DIV  = 2'd1;
  localparam logic [1:0] P_FIX  = 2'd2;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

  logic [1:0]        phase;
  logic [STEP_W-1:0] step;
  logic [WORD_W-1:0] dvd;
  logic [WORD_W-1:0] dvs;
  logic [WORD_W-1:0] rem;
  logic              neg_q;
  logic              neg_r;
  logic              is_rem;

  logic [WORD_W-1:0] l_mag;
  logic [WORD_W-1:0] r_mag;
  logic [WORD_W-1:0] prod_lo;
  logic [WORD_W:0]   trial;

  assign l_mag   = left[WORD_W-1] ? (~left + WORD_W'(1)) : left;
  assign r_mag   = right[WORD_W-1] ? (~right + WORD_W'(1)) : right;
  assign prod_lo = left * right;
  assign trial   = {rem, dvd[WORD_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (req.start) begin
            case (req.op) inside
              OP_ADD: begin
                result <= left + right;
                done   <= 1'b1;
              end
              OP_SUB: begin
                result <= left - right;
                done   <= 1'b1;
              end
              OP_MUL: begin
                result <= prod_lo;
                done   <= 1'b1;
              end
              OP_DIV, OP_REM: begin
                dvd    <= l_mag;
                dvs    <= r_mag;
                rem    <= '0;
                step   <= '0;
                neg_q  <= left[WORD_W-1] ^ right[WORD_W-1];
                neg_r  <= left[WORD_W-1];
                is_rem <= (req.op == OP_REM);
                phase  <= P_DIV;
              end
              default: begin
                result <= '0;
                done   <= 1'b1;
              end
            endcase
          end
        end
        P_DIV: begin
          if (!trial[WORD_W]) begin
            rem <= trial[WORD_W-1:0];
            dvd <= {dvd[WORD_W-2:0], 1'b1};
          end else begin
            rem <= {rem[WORD_W-2:0], dvd[WORD_W-1]};
            dvd <= {dvd[WORD_W-2:0], 1'b0};
          end
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) begin
            phase <= P_FIX;
          end
        end
        P_FIX: begin
          if (is_rem) begin
            result <= neg_r ? (~rem + WORD_W'(1)) : rem;
          end else begin
            result <= neg_q ? (~dvd + WORD_W'(1)) : dvd;
          end
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Reverse Polish evaluator: one token word in, one result word out.
//
//   channel | handshake                   | payload
//   token   | token_valid / token_stall   | opcode, operand
//   result  | result_valid / result_stall | value, status, done_res
//
// Push, ignored opcodes and stack errors go straight from idle to output;
// a finish with one value and a divide by zero pass through execute first.
// Add, subtract and multiply pass through execute and wait for the ALU.
// Divide and remainder wait on the one-bit-per-cycle divider.
// Reset clears the stack count; stack contents are not cleared.
// A result stalled at the output holds the next token until it is taken.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              token_valid,
  output logic                              token_stall,
  input  logic [pee_pkg::OPC_W-1:0]         opcode,
  input  logic signed [pee_pkg::WORD_W-1:0] operand,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [pee_pkg::WORD_W-1:0] value,
  output logic [pee_pkg::STS_W-1:0]         status,
  output logic                              done_res
);
  import pee_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [OPC_W-1:0]  op;
  logic [WORD_W-1:0] res_value;
  logic [WORD_W-1:0] res_value_next;
  logic [STS_W-1:0]  res_status;
  logic [STS_W-1:0]  res_status_next;
  logic              res_done;
  logic              res_done_next;

  logic              accept;
  logic              load;
  logic [CW-1:0]     cm1;
  logic [CW-1:0]     cm2;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;
  alu_req_t          alu_req;
  logic              alu_done;
  logic [WORD_W-1:0] alu_result;

  assign token_stall = (state != S_IDLE);
  assign accept      = token_valid && !token_stall;
  assign load        = !result_valid || !result_stall;
  assign cm1         = count - CW'(1);
  assign cm2         = count - CW'(2);
  assign waddr       = (state == S_IDLE) ? count[AW-1:0] : cm2[AW-1:0];
  assign wdata       = (state == S_IDLE) ? $unsigned(operand) : alu_result;

  pee_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (cm1[AW-1:0]),
    .raddr_b (cm2[AW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  pee_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .left   (rdata_b),
    .right  (rdata_a),
    .done   (alu_done),
    .result (alu_result)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    res_value_next  = res_value;
    res_status_next = res_status;
    res_done_next   = res_done;
    we              = 1'b0;
    alu_req.start   = 1'b0;
    alu_req.op      = op;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_value_next  = '0;
          res_status_next = ST_OK;
          res_done_next   = 1'b0;
          state_next      = S_OUT;
          unique case (opcode) inside
            OP_PUSH: begin
              if (count >= FULL) begin
                res_status_next = ST_OVERFLOW;
              end else begin
                we         = 1'b1;
                count_next = count + CW'(1);
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM: begin
              if (count < CW'(2)) begin
                res_status_next = ST_UNDERFLOW;
              end else begin
                state_next = S_EXEC;
              end
            end
            OP_FINISH: begin
              res_done_next = 1'b1;
              count_next    = '0;
              if (count == '0) begin
                res_status_next = ST_UNDERFLOW;
              end else if (count == CW'(1)) begin
                state_next = S_EXEC;
              end else begin
                res_status_next = ST_LEFTOVER;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EXEC: begin
        if (op == OP_FINISH) begin
          res_value_next = rdata_a;
          state_next     = S_OUT;
        end else if ((op == OP_DIV || op == OP_REM) && rdata_a == '0) begin
          res_status_next = ST_DIVZERO;
          state_next      = S_OUT;
        end else begin
          alu_req.start = 1'b1;
          state_next    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (alu_done) begin
          we             = 1'b1;
          count_next     = count - CW'(1);
          res_value_next = alu_result;
          state_next     = S_OUT;
        end
      end
      S_OUT: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_OUT && load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_value  <= res_value_next;
    res_status <= res_status_next;
    res_done   <= res_done_next;
    if (accept) begin
      op <= opcode;
    end
    if (state == S_OUT && load) begin
      value    <= $signed(res_value);
      status   <= res_status;
      done_res <= res_done;
    end
  end

  finish_clears_stack: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_FINISH) |=> (count == '0))
    else $error("stack count not cleared after finish word");

  alu_done_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> (state == S_WAIT))
    else $error("arithmetic unit finished outside its wait state");

  leftover_ends_expression: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == ST_LEFTOVER) |-> done_res)
    else $error("leftover status on a word that does not end the expression");

endmodule
